@@ design/jarf_pkg.sv @@
// jarf_pkg: shared types, constants and the twist dead-zone table
// for the joystick axis report filter; no dependencies
`default_nettype none

package jarf_pkg;

  localparam int unsigned AXIS_W     = 10;
  localparam int unsigned SLIDER_W   = 7;
  localparam int unsigned TWIST_W    = 6;
  localparam int unsigned COUNT_W    = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [7:0]  FILTER_KIND   = 8'd1;
  localparam logic [15:0] FILTER_LENGTH = 16'd9;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_XY_HYSTERESIS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLIDER_IDLE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLIDER_FAST      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERSIST     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_PERSIST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_WINDOW     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_SPAN      = 3'd6;

  // register reset values
  localparam logic [AXIS_W-1:0]   RST_XY_HYSTERESIS  = 10'd4;
  localparam logic [SLIDER_W-1:0] RST_SLIDER_IDLE    = 7'd3;
  localparam logic [SLIDER_W-1:0] RST_SLIDER_FAST    = 7'd8;
  localparam logic [COUNT_W-1:0]  RST_FAST_PERSIST   = 10'd6;
  localparam logic [COUNT_W-1:0]  RST_MEDIUM_PERSIST = 10'd250;
  localparam logic [COUNT_W-1:0]  RST_TRACK_WINDOW   = 10'd100;
  localparam logic [SLIDER_W-1:0] RST_STABLE_SPAN    = 7'd3;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef struct packed {
    logic [AXIS_W-1:0]   xy_hysteresis;
    logic [SLIDER_W-1:0] slider_idle_band;
    logic [SLIDER_W-1:0] slider_fast_delta;
    logic [COUNT_W-1:0]  slider_fast_persist;
    logic [COUNT_W-1:0]  slider_medium_persist;
    logic [COUNT_W-1:0]  slider_track_window;
    logic [SLIDER_W-1:0] slider_stable_span;
  } cfg_t;

  // control from the top level to the axis units
  typedef struct packed {
    logic step;
    logic first;
  } step_ctl_t;

  localparam logic [TWIST_W-1:0] TWIST_TABLE [64] = '{
    6'd0,  6'd1,  6'd3,  6'd4,  6'd5,  6'd7,  6'd8,  6'd9,
    6'd11, 6'd12, 6'd13, 6'd15, 6'd16, 6'd18, 6'd19, 6'd20,
    6'd22, 6'd23, 6'd24, 6'd26, 6'd27, 6'd28, 6'd30, 6'd31,
    6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32,
    6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd33,
    6'd34, 6'd36, 6'd37, 6'd38, 6'd39, 6'd41, 6'd42, 6'd43,
    6'd44, 6'd46, 6'd47, 6'd48, 6'd49, 6'd51, 6'd52, 6'd53,
    6'd54, 6'd56, 6'd57, 6'd58, 6'd59, 6'd61, 6'd62, 6'd63
  };

endpackage

`default_nettype wire

@@ design/jarf_cfg_regs.sv @@
// jarf_cfg_regs: configuration register file with write channel
// depends on jarf_pkg
`default_nettype none

module jarf_cfg_regs
  import jarf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t regs;
  logic wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.xy_hysteresis         <= RST_XY_HYSTERESIS;
      regs.slider_idle_band      <= RST_SLIDER_IDLE;
      regs.slider_fast_delta     <= RST_SLIDER_FAST;
      regs.slider_fast_persist   <= RST_FAST_PERSIST;
      regs.slider_medium_persist <= RST_MEDIUM_PERSIST;
      regs.slider_track_window   <= RST_TRACK_WINDOW;
      regs.slider_stable_span    <= RST_STABLE_SPAN;
    end else if (wr) begin
      case (cfg_index)
        CFG_XY_HYSTERESIS:  regs.xy_hysteresis         <= cfg_data[AXIS_W-1:0];
        CFG_SLIDER_IDLE:    regs.slider_idle_band      <= cfg_data[SLIDER_W-1:0];
        CFG_SLIDER_FAST:    regs.slider_fast_delta     <= cfg_data[SLIDER_W-1:0];
        CFG_FAST_PERSIST:   regs.slider_fast_persist   <= cfg_data[COUNT_W-1:0];
        CFG_MEDIUM_PERSIST: regs.slider_medium_persist <= cfg_data[COUNT_W-1:0];
        CFG_TRACK_WINDOW:   regs.slider_track_window   <= cfg_data[COUNT_W-1:0];
        CFG_STABLE_SPAN:    regs.slider_stable_span    <= cfg_data[SLIDER_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/jarf_xy_twist.sv @@
// jarf_xy_twist: X/Y tracking hysteresis and twist dead zone with slew limit
// holds held_x, held_y, held_twist; depends on jarf_pkg
`default_nettype none

module jarf_xy_twist
  import jarf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  step_ctl_t               ctl,
  input  wire logic [AXIS_W-1:0]  hyst,
  input  wire logic [AXIS_W-1:0]  raw_x,
  input  wire logic [AXIS_W-1:0]  raw_y,
  input  wire logic [TWIST_W-1:0] raw_z,
  output logic      [AXIS_W-1:0]  held_x_next,
  output logic      [AXIS_W-1:0]  held_y_next,
  output logic      [TWIST_W-1:0] held_twist_next
);

  logic [AXIS_W-1:0]  held_x;
  logic [AXIS_W-1:0]  held_y;
  logic [TWIST_W-1:0] held_twist;
  logic [AXIS_W-1:0]  fx;
  logic [AXIS_W-1:0]  fy;
  logic [TWIST_W-1:0] target;

  function automatic logic [AXIS_W-1:0] hyst_follow(
    input logic [AXIS_W-1:0] raw,
    input logic [AXIS_W-1:0] held,
    input logic [AXIS_W-1:0] h
  );
    logic [AXIS_W:0] held_hi;
    logic [AXIS_W:0] raw_hi;
    logic [AXIS_W:0] raw_lo;
    begin
      held_hi = {1'b0, held} + {1'b0, h};
      raw_hi  = {1'b0, raw} + {1'b0, h};
      raw_lo  = {1'b0, raw} - {1'b0, h};
      if ({1'b0, raw} > held_hi) begin
        hyst_follow = raw_lo[AXIS_W-1:0];
      end else if (raw_hi < {1'b0, held}) begin
        hyst_follow = raw_hi[AXIS_W-1:0];
      end else begin
        hyst_follow = held;
      end
    end
  endfunction

  assign target = TWIST_TABLE[raw_z];
  assign fx     = hyst_follow(raw_x, held_x, hyst);
  assign fy     = hyst_follow(raw_y, held_y, hyst);

  always_comb begin
    if (ctl.first) begin
      held_x_next     = raw_x;
      held_y_next     = raw_y;
      held_twist_next = target;
    end else begin
      held_x_next = fx;
      held_y_next = fy;
      if (target > held_twist) begin
        held_twist_next = held_twist + TWIST_W'(1);
      end else if (target < held_twist) begin
        held_twist_next = held_twist - TWIST_W'(1);
      end else begin
        held_twist_next = held_twist;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_x     <= '0;
      held_y     <= '0;
      held_twist <= '0;
    end else if (ctl.step) begin
      held_x     <= held_x_next;
      held_y     <= held_y_next;
      held_twist <= held_twist_next;
    end
  end

endmodule

`default_nettype wire

@@ design/jarf_slider.sv @@
// jarf_slider: slider idle band, persistence counting and tracking window
// holds all slider state; depends on jarf_pkg
`default_nettype none

module jarf_slider
  import jarf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  step_ctl_t                ctl,
  input  cfg_t                     cfg,
  input  wire logic [SLIDER_W-1:0] raw,
  output logic      [SLIDER_W-1:0] held_throttle_next
);

  logic [SLIDER_W-1:0] held_throttle;
  dir_t                cand;
  logic                tracking;
  logic [COUNT_W-1:0]  persist;
  logic [COUNT_W-1:0]  win_count;
  logic [SLIDER_W-1:0] win_min;
  logic [SLIDER_W-1:0] win_max;

  dir_t                cand_next;
  logic                tracking_next;
  logic [COUNT_W-1:0]  persist_next;
  logic [COUNT_W-1:0]  win_count_next;
  logic [SLIDER_W-1:0] win_min_next;
  logic [SLIDER_W-1:0] win_max_next;

  logic [SLIDER_W-1:0] mag;
  dir_t                dir;
  logic                big_move;
  logic [COUNT_W-1:0]  need;
  logic [COUNT_W-1:0]  pc;
  logic [COUNT_W-1:0]  wc;
  logic [SLIDER_W-1:0] wmin;
  logic [SLIDER_W-1:0] wmax;
  logic [SLIDER_W-1:0] span;

  always_comb begin
    held_throttle_next = held_throttle;
    cand_next          = cand;
    tracking_next      = tracking;
    persist_next       = persist;
    win_count_next     = win_count;
    win_min_next       = win_min;
    win_max_next       = win_max;

    if (raw >= held_throttle) begin
      mag = raw - held_throttle;
      dir = DIR_UP;
    end else begin
      mag = held_throttle - raw;
      dir = DIR_DOWN;
    end
    big_move = mag >= cfg.slider_fast_delta;
    need     = big_move ? cfg.slider_fast_persist : cfg.slider_medium_persist;

    if (cand != dir) begin
      pc = COUNT_W'(1);
    end else if (persist < need) begin
      pc = persist + COUNT_W'(1);
    end else begin
      pc = persist;
    end

    // tracking window bookkeeping
    if (win_count == '0) begin
      wc   = COUNT_W'(1);
      wmin = raw;
      wmax = raw;
    end else begin
      wc   = (win_count < cfg.slider_track_window) ? win_count + COUNT_W'(1) : win_count;
      wmin = (raw < win_min) ? raw : win_min;
      wmax = (raw > win_max) ? raw : win_max;
    end
    span = wmax - wmin;

    if (ctl.first) begin
      held_throttle_next = raw;
      cand_next          = DIR_NONE;
      tracking_next      = 1'b0;
      persist_next       = '0;
      win_count_next     = '0;
      win_min_next       = raw;
      win_max_next       = raw;
    end else if (tracking) begin
      held_throttle_next = raw;
      cand_next          = DIR_NONE;
      persist_next       = '0;
      if (wc >= cfg.slider_track_window) begin
        if (span <= cfg.slider_stable_span) begin
          tracking_next = 1'b0;
        end
        win_count_next = '0;
        win_min_next   = raw;
        win_max_next   = raw;
      end else begin
        win_count_next = wc;
        win_min_next   = wmin;
        win_max_next   = wmax;
      end
    end else if (mag <= cfg.slider_idle_band) begin
      cand_next    = DIR_NONE;
      persist_next = '0;
    end else if (pc >= need) begin
      held_throttle_next = raw;
      cand_next          = DIR_NONE;
      persist_next       = '0;
      if (big_move) begin
        tracking_next  = 1'b1;
        win_count_next = COUNT_W'(1);
        win_min_next   = raw;
        win_max_next   = raw;
      end
    end else begin
      cand_next    = dir;
      persist_next = pc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_throttle <= '0;
      cand          <= DIR_NONE;
      tracking      <= 1'b0;
      persist       <= '0;
      win_count     <= '0;
      win_min       <= '0;
      win_max       <= '0;
    end else if (ctl.step) begin
      held_throttle <= held_throttle_next;
      cand          <= cand_next;
      tracking      <= tracking_next;
      persist       <= persist_next;
      win_count     <= win_count_next;
      win_min       <= win_min_next;
      win_max       <= win_max_next;
    end
  end

  a_track_no_cand: assert property (@(posedge clk) disable iff (rst)
    tracking |-> (cand == DIR_NONE) && (persist == '0))
    else $error("candidate left set in tracking mode");

  a_track_window_order: assert property (@(posedge clk) disable iff (rst)
    tracking |-> (win_max >= win_min))
    else $error("tracking window min above max");

  a_persist_has_dir: assert property (@(posedge clk) disable iff (rst)
    (persist != '0) |-> (cand != DIR_NONE))
    else $error("persist count without candidate direction");

endmodule

`default_nettype wire

@@ design/joystick_axis_report_filter_top.sv @@
// joystick_axis_report_filter_top: input register, axis filters, result register
// depends on jarf_pkg, jarf_cfg_regs, jarf_xy_twist, jarf_slider
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------
//   in       | in_valid / in_stall    | host_instance .. hat_byte
//   out      | out_valid / out_stall  | out_instance .. out_hat
//   cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// a beat is taken every cycle while in_stall is low; it passes the input register, then the result register
// the filter state updates as a filtered beat moves from the input to the result register
// in_stall rises only when both the input and the result registers are full and out is stalled
// rst is synchronous and restores register defaults and clears all filter state
`default_nettype none

module joystick_axis_report_filter_top
  import jarf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            host_instance,
  input  wire logic [7:0]            report_kind,
  input  wire logic [15:0]           report_length,
  input  wire logic [15:0]           button_bits,
  input  wire logic [AXIS_W-1:0]     raw_x_axis,
  input  wire logic [AXIS_W-1:0]     raw_y_axis,
  input  wire logic [TWIST_W-1:0]    raw_twist,
  input  wire logic [SLIDER_W-1:0]   raw_throttle,
  input  wire logic [7:0]            hat_byte,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [7:0]            out_instance,
  output logic      [7:0]            out_kind,
  output logic                       was_filtered,
  output logic      [15:0]           out_buttons,
  output logic      [AXIS_W-1:0]     out_x_axis,
  output logic      [AXIS_W-1:0]     out_y_axis,
  output logic      [TWIST_W-1:0]    out_twist,
  output logic      [SLIDER_W-1:0]   out_throttle,
  output logic      [7:0]            out_hat,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;

  // input register
  logic                s1_valid;
  logic [7:0]          s1_instance;
  logic [7:0]          s1_kind;
  logic                s1_filt;
  logic [15:0]         s1_buttons;
  logic [AXIS_W-1:0]   s1_x;
  logic [AXIS_W-1:0]   s1_y;
  logic [TWIST_W-1:0]  s1_z;
  logic [SLIDER_W-1:0] s1_s;
  logic [7:0]          s1_hat;

  logic                initialised;
  logic                advance;
  logic                in_take;
  logic                move;
  step_ctl_t           ctl;

  logic [AXIS_W-1:0]   held_x_next;
  logic [AXIS_W-1:0]   held_y_next;
  logic [TWIST_W-1:0]  held_twist_next;
  logic [SLIDER_W-1:0] held_throttle_next;

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign in_take   = in_valid && !in_stall;
  assign move      = s1_valid && advance;
  assign ctl.step  = move && s1_filt;
  assign ctl.first = !initialised;

  jarf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  jarf_xy_twist u_xy_twist (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .hyst            (cfg.xy_hysteresis),
    .raw_x           (s1_x),
    .raw_y           (s1_y),
    .raw_z           (s1_z),
    .held_x_next     (held_x_next),
    .held_y_next     (held_y_next),
    .held_twist_next (held_twist_next)
  );

  jarf_slider u_slider (
    .clk                (clk),
    .rst                (rst),
    .ctl                (ctl),
    .cfg                (cfg),
    .raw                (s1_s),
    .held_throttle_next (held_throttle_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      initialised <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (ctl.step) begin
        initialised <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_instance <= host_instance;
      s1_kind     <= report_kind;
      s1_filt     <= (report_kind == FILTER_KIND) && (report_length == FILTER_LENGTH);
      s1_buttons  <= button_bits;
      s1_x        <= raw_x_axis;
      s1_y        <= raw_y_axis;
      s1_z        <= raw_twist;
      s1_s        <= raw_throttle;
      s1_hat      <= hat_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_instance <= s1_instance;
      out_kind     <= s1_kind;
      was_filtered <= s1_filt;
      out_buttons  <= s1_buttons;
      out_hat      <= s1_hat;
      out_x_axis   <= s1_filt ? held_x_next : s1_x;
      out_y_axis   <= s1_filt ? held_y_next : s1_y;
      out_twist    <= s1_filt ? held_twist_next : s1_z;
      out_throttle <= s1_filt ? held_throttle_next : s1_s;
    end
  end

  a_held_beat_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && out_stall) |=> s1_valid)
    else $error("input register beat lost while result stalled");

  a_init_after_step: assert property (@(posedge clk) disable iff (rst)
    ctl.step |=> initialised)
    else $error("filtered beat did not mark state initialised");

  a_init_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(initialised) |-> $past(move && s1_filt))
    else $error("state initialised without a filtered beat");

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// tb: self-checking bench for joystick_axis_report_filter_top
// holds its own model of the axis filters; depends on jarf_pkg and the design sources
`timescale 1ns / 100ps

module tb;
  import jarf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [7:0]          inst_no;
    logic [7:0]          kind;
    logic [15:0]         length;
    logic [15:0]         buttons;
    logic [AXIS_W-1:0]   x;
    logic [AXIS_W-1:0]   y;
    logic [TWIST_W-1:0]  twist;
    logic [SLIDER_W-1:0] throttle;
    logic [7:0]          hat;
  } joystick_report_t;

  typedef struct packed {
    logic [7:0]          inst_no;
    logic [7:0]          kind;
    logic                filtered;
    logic [15:0]         buttons;
    logic [AXIS_W-1:0]   x;
    logic [AXIS_W-1:0]   y;
    logic [TWIST_W-1:0]  twist;
    logic [SLIDER_W-1:0] throttle;
    logic [7:0]          hat;
  } filtered_report_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            host_instance;
  logic [7:0]            report_kind;
  logic [15:0]           report_length;
  logic [15:0]           button_bits;
  logic [AXIS_W-1:0]     raw_x_axis;
  logic [AXIS_W-1:0]     raw_y_axis;
  logic [TWIST_W-1:0]    raw_twist;
  logic [SLIDER_W-1:0]   raw_throttle;
  logic [7:0]            hat_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            out_instance;
  logic [7:0]            out_kind;
  logic                  was_filtered;
  logic [15:0]           out_buttons;
  logic [AXIS_W-1:0]     out_x_axis;
  logic [AXIS_W-1:0]     out_y_axis;
  logic [TWIST_W-1:0]    out_twist;
  logic [SLIDER_W-1:0]   out_throttle;
  logic [7:0]            out_hat;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  joystick_axis_report_filter_top i_dut (.*);

  // filter model state
  cfg_t                regs_now;
  logic                seen_first;
  logic [AXIS_W-1:0]   kept_x;
  logic [AXIS_W-1:0]   kept_y;
  logic [SLIDER_W-1:0] kept_throttle;
  logic [TWIST_W-1:0]  kept_twist;
  dir_t                pending_dir;
  logic                tracking;
  logic [COUNT_W-1:0]  streak;
  logic [COUNT_W-1:0]  win_count;
  logic [SLIDER_W-1:0] win_lo;
  logic [SLIDER_W-1:0] win_hi;

  filtered_report_t expected_q[$];
  filtered_report_t due;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int mismatches = 0;
  int cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("joystick_axis_report_filter_top verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
      stall_left <= $urandom_range(11, 0);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [AXIS_W-1:0] follow_axis(input logic [AXIS_W-1:0] raw,
                                                    input logic [AXIS_W-1:0] held);
    int h;
    int rv;
    int hv;
    h = int'(regs_now.xy_hysteresis);
    rv = int'(raw);
    hv = int'(held);
    if (rv > hv + h) return AXIS_W'(rv - h);
    if (rv + h < hv) return AXIS_W'(rv + h);
    return held;
  endfunction

  function automatic filtered_report_t predict_report(input joystick_report_t r);
    filtered_report_t res;
    int mag;
    int need;
    logic big_move;
    dir_t move_dir;
    logic [TWIST_W-1:0] target;
    res.inst_no = r.inst_no;
    res.kind = r.kind;
    res.buttons = r.buttons;
    res.hat = r.hat;
    res.filtered = (r.kind == FILTER_KIND) && (r.length == FILTER_LENGTH);
    if (!res.filtered) begin
      res.x = r.x;
      res.y = r.y;
      res.twist = r.twist;
      res.throttle = r.throttle;
      return res;
    end
    target = TWIST_TABLE[r.twist];
    if (!seen_first) begin
      kept_x = r.x;
      kept_y = r.y;
      kept_throttle = r.throttle;
      kept_twist = target;
      pending_dir = DIR_NONE;
      tracking = 1'b0;
      streak = '0;
      win_count = '0;
      win_lo = r.throttle;
      win_hi = r.throttle;
      seen_first = 1'b1;
    end else begin
      kept_x = follow_axis(r.x, kept_x);
      kept_y = follow_axis(r.y, kept_y);
      if (tracking) begin
        kept_throttle = r.throttle;
        if (win_count == '0) begin
          win_lo = r.throttle;
          win_hi = r.throttle;
          win_count = COUNT_W'(1);
        end else begin
          if (r.throttle < win_lo) win_lo = r.throttle;
          if (r.throttle > win_hi) win_hi = r.throttle;
          if (win_count < regs_now.slider_track_window) win_count = win_count + COUNT_W'(1);
        end
        if (win_count >= regs_now.slider_track_window) begin
          if (SLIDER_W'(win_hi - win_lo) <= regs_now.slider_stable_span) tracking = 1'b0;
          win_count = '0;
          win_lo = r.throttle;
          win_hi = r.throttle;
        end
        pending_dir = DIR_NONE;
        streak = '0;
      end else begin
        if (r.throttle >= kept_throttle) begin
          mag = r.throttle - kept_throttle;
          move_dir = DIR_UP;
        end else begin
          mag = kept_throttle - r.throttle;
          move_dir = DIR_DOWN;
        end
        if (mag <= regs_now.slider_idle_band) begin
          pending_dir = DIR_NONE;
          streak = '0;
        end else begin
          big_move = mag >= regs_now.slider_fast_delta;
          need = big_move ? regs_now.slider_fast_persist : regs_now.slider_medium_persist;
          if (move_dir != pending_dir) begin
            pending_dir = move_dir;
            streak = COUNT_W'(1);
          end else if (streak < need) begin
            streak = streak + COUNT_W'(1);
          end
          if (streak >= need) begin
            kept_throttle = r.throttle;
            pending_dir = DIR_NONE;
            streak = '0;
            if (big_move) begin
              tracking = 1'b1;
              win_count = COUNT_W'(1);
              win_lo = r.throttle;
              win_hi = r.throttle;
            end
          end
        end
      end
      if (target > kept_twist) kept_twist = kept_twist + TWIST_W'(1);
      else if (target < kept_twist) kept_twist = kept_twist - TWIST_W'(1);
    end
    res.x = kept_x;
    res.y = kept_y;
    res.twist = kept_twist;
    res.throttle = kept_throttle;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t result beat with none outstanding", $time);
      end else begin
        due = expected_q.pop_front();
        check_field("out_instance", due.inst_no, out_instance);
        check_field("out_kind", due.kind, out_kind);
        check_field("was_filtered", due.filtered, was_filtered);
        check_field("out_buttons", due.buttons, out_buttons);
        check_field("out_x_axis", due.x, out_x_axis);
        check_field("out_y_axis", due.y, out_y_axis);
        check_field("out_twist", due.twist, out_twist);
        check_field("out_throttle", due.throttle, out_throttle);
        check_field("out_hat", due.hat, out_hat);
      end
    end
  end

  task automatic send_report(input joystick_report_t r);
    if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(11, 0)) @(negedge clk);
    end
    @(negedge clk);
    host_instance <= r.inst_no;
    report_kind <= r.kind;
    report_length <= r.length;
    button_bits <= r.buttons;
    raw_x_axis <= r.x;
    raw_y_axis <= r.y;
    raw_twist <= r.twist;
    raw_throttle <= r.throttle;
    hat_byte <= r.hat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(predict_report(r));
  endtask

  function automatic joystick_report_t joystick_report(input int x, input int y,
                                                       input int tw, input int th);
    joystick_report_t r;
    r.inst_no = 8'($urandom);
    r.kind = FILTER_KIND;
    r.length = FILTER_LENGTH;
    r.buttons = 16'($urandom);
    r.x = AXIS_W'(x);
    r.y = AXIS_W'(y);
    r.twist = TWIST_W'(tw);
    r.throttle = SLIDER_W'(th);
    r.hat = 8'($urandom);
    return r;
  endfunction

  function automatic joystick_report_t raw_report(input logic [7:0] kind,
                                                  input logic [15:0] length, input bit ones);
    joystick_report_t r;
    r = ones ? '1 : '0;
    r.kind = kind;
    r.length = length;
    return r;
  endfunction

  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_XY_HYSTERESIS:  regs_now.xy_hysteresis = val;
      CFG_SLIDER_IDLE:    regs_now.slider_idle_band = val[SLIDER_W-1:0];
      CFG_SLIDER_FAST:    regs_now.slider_fast_delta = val[SLIDER_W-1:0];
      CFG_FAST_PERSIST:   regs_now.slider_fast_persist = val;
      CFG_MEDIUM_PERSIST: regs_now.slider_medium_persist = val;
      CFG_TRACK_WINDOW:   regs_now.slider_track_window = val;
      CFG_STABLE_SPAN:    regs_now.slider_stable_span = val[SLIDER_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_filter(input int h, input int idle, input int fast, input int fp,
                                input int mp, input int win, input int span);
    write_reg(CFG_XY_HYSTERESIS, CFG_DATA_W'(h));
    write_reg(CFG_SLIDER_IDLE, CFG_DATA_W'(idle));
    write_reg(CFG_SLIDER_FAST, CFG_DATA_W'(fast));
    write_reg(CFG_FAST_PERSIST, CFG_DATA_W'(fp));
    write_reg(CFG_MEDIUM_PERSIST, CFG_DATA_W'(mp));
    write_reg(CFG_TRACK_WINDOW, CFG_DATA_W'(win));
    write_reg(CFG_STABLE_SPAN, CFG_DATA_W'(span));
  endtask

  function automatic int clip(input int v, input int top);
    return (v < 0) ? 0 : (v > top) ? top : v;
  endfunction

  task automatic run_random_phase(input int count, input int gap, input int stall);
    joystick_report_t r;
    int n;
    int pick;
    int cx;
    int cy;
    int ctw;
    int base;
    int th;
    gap_pct = gap;
    stall_pct = stall;
    cx = $urandom_range(1023, 0);
    cy = $urandom_range(1023, 0);
    ctw = $urandom_range(63, 0);
    base = $urandom_range(127, 0);
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99, 0);
      if (pick < 8) begin
        r = joystick_report($urandom, $urandom, $urandom, $urandom);
        r.kind = 8'($urandom);
        r.length = 16'($urandom);
        case (pick % 4)
          1: r.kind = FILTER_KIND;
          2: r.length = FILTER_LENGTH;
          3: begin
            r.kind = FILTER_KIND;
            r.length = FILTER_LENGTH ^ (16'd1 << $urandom_range(15, 0));
          end
          default: ;
        endcase
      end else begin
        cx = ($urandom_range(9, 0) == 0) ? $urandom_range(1023, 0) :
             clip(cx + $urandom_range(16, 0) - 8, 1023);
        cy = ($urandom_range(9, 0) == 0) ? $urandom_range(1023, 0) :
             clip(cy + $urandom_range(16, 0) - 8, 1023);
        if ($urandom_range(29, 0) == 0) cx = $urandom_range(1, 0) ? 1023 : 0;
        if ($urandom_range(29, 0) == 0) cy = $urandom_range(1, 0) ? 1023 : 0;
        if ($urandom_range(4, 0) == 0) ctw = $urandom_range(63, 0);
        pick = $urandom_range(99, 0);
        if (pick < 3) base = $urandom_range(1, 0) ? 127 : 0;
        else if (pick < 6) base = $urandom_range(127, 0);
        else if (pick < 10) base = clip(base + ($urandom_range(1, 0) ? 1 : -1) *
                                        $urandom_range(12, 2), 127);
        th = base;
        if ($urandom_range(9, 0) < 3) th = clip(base + $urandom_range(2, 0) - 1, 127);
        r = joystick_report(cx, cy, ctw, th);
      end
      send_report(r);
    end
  endtask

  task automatic program_random_filter();
    int idle;
    idle = $urandom_range(4, 0);
    program_filter($urandom_range(24, 0), ($urandom_range(7, 0) << 7) | idle,
                   ($urandom_range(7, 0) << 7) | (idle + $urandom_range(12, 1)),
                   $urandom_range(8, 0), $urandom_range(12, 0), $urandom_range(24, 0),
                   ($urandom_range(7, 0) << 7) | $urandom_range(6, 0));
  endtask

  task automatic test_passthrough();
    gap_pct = 20;
    stall_pct = 20;
    send_report(raw_report(8'd0, FILTER_LENGTH, 1'b1));
    send_report(raw_report(FILTER_KIND, 16'd8, 1'b1));
    send_report(raw_report(8'hff, 16'hffff, 1'b1));
    send_report(raw_report(FILTER_KIND, 16'h0109, 1'b0));
  endtask

  task automatic test_first_report();
    send_report(joystick_report(1023, 0, 63, 127));
    send_report(raw_report(8'd2, FILTER_LENGTH, 1'b0));
    send_report(joystick_report(1023, 0, 63, 127));
  endtask

  task automatic test_axes_and_twist();
    send_report(joystick_report(0, 1023, 0, 127));
    send_report(joystick_report(2, 1023, 24, 127));
    send_report(joystick_report(9, 1015, 38, 127));
    send_report(joystick_report(9, 1015, 31, 127));
  endtask

  task automatic test_slider_moves();
    settle_block();
    program_filter(4, 1, 8, 2, 3, 3, 3);
    // large move down, then tracking until the window settles
    send_report(joystick_report(9, 1015, 31, 100));
    send_report(joystick_report(9, 1015, 31, 100));
    send_report(joystick_report(9, 1015, 31, 101));
    send_report(joystick_report(9, 1015, 31, 102));
    send_report(joystick_report(9, 1015, 31, 101));
    // medium move up must persist
    send_report(joystick_report(9, 1015, 31, 106));
    send_report(joystick_report(9, 1015, 31, 106));
    send_report(joystick_report(9, 1015, 31, 106));
  endtask

  task automatic test_register_corners();
    settle_block();
    program_filter(0, 0, 0, 0, 0, 0, 0);
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    send_report(joystick_report(500, 3, 10, 50));
    send_report(joystick_report(501, 2, 10, 60));
    send_report(joystick_report(501, 2, 10, 60));
    send_report(joystick_report(0, 1023, 10, 0));
    settle_block();
    program_filter(1023, 1023, 127, 1023, 1023, 1023, 127);
    send_report(joystick_report(1023, 0, 63, 127));
    send_report(joystick_report(0, 1023, 0, 0));
  endtask

  task automatic test_random_traffic();
    int k;
    settle_block();
    program_filter(RST_XY_HYSTERESIS, RST_SLIDER_IDLE, RST_SLIDER_FAST, RST_FAST_PERSIST,
                   RST_MEDIUM_PERSIST, RST_TRACK_WINDOW, RST_STABLE_SPAN);
    run_random_phase(90, 25, 25);
    settle_block();
    program_filter(1023, 127, 127, 1023, 1023, 1023, 127);
    run_random_phase(40, 30, 30);
    settle_block();
    program_filter(0, 0, 0, 0, 0, 0, 0);
    run_random_phase(60, 10, 40);
    for (k = 0; k < 4; k++) begin
      settle_block();
      program_random_filter();
      run_random_phase(80, ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(40, 5),
                       ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(40, 5));
    end
  endtask

  task automatic test_quiet_tail();
    run_random_phase(60, 0, 0);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    host_instance = '0;
    report_kind = '0;
    report_length = '0;
    button_bits = '0;
    raw_x_axis = '0;
    raw_y_axis = '0;
    raw_twist = '0;
    raw_throttle = '0;
    hat_byte = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    regs_now = '{xy_hysteresis: RST_XY_HYSTERESIS, slider_idle_band: RST_SLIDER_IDLE,
                 slider_fast_delta: RST_SLIDER_FAST, slider_fast_persist: RST_FAST_PERSIST,
                 slider_medium_persist: RST_MEDIUM_PERSIST,
                 slider_track_window: RST_TRACK_WINDOW, slider_stable_span: RST_STABLE_SPAN};
    seen_first = 1'b0;
    kept_x = '0;
    kept_y = '0;
    kept_throttle = '0;
    kept_twist = '0;
    pending_dir = DIR_NONE;
    tracking = 1'b0;
    streak = '0;
    win_count = '0;
    win_lo = '0;
    win_hi = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_passthrough();
    test_first_report();
    test_axes_and_twist();
    test_slider_moves();
    test_register_corners();
    test_random_traffic();
    test_quiet_tail();

    settle_block();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("joystick_axis_report_filter_top verification clean");
    end else begin
      $display("joystick_axis_report_filter_top verification failed");
    end
    $finish;
  end

endmodule
